@@ hw/rtl/prid_pkg.sv @@
// Package for the path resource-ID block: beat and result types, character
// codes, byte normalization and the byte-wide reflected CRC-32 update.
// No dependencies.
`timescale 1ns / 1ps

package prid_pkg;

  localparam logic [31:0] CrcPoly     = 32'hEDB8_8320;
  localparam logic [7:0]  SepChar     = 8'h5C;  // backslash
  localparam logic [7:0]  AltSepChar  = 8'h2F;  // forward slash
  localparam logic [7:0]  DotChar     = 8'h2E;
  localparam logic [7:0]  UpperFirst  = 8'h41;
  localparam logic [7:0]  UpperLast   = 8'h5A;
  localparam logic [7:0]  CaseOffset  = 8'h20;
  localparam logic [2:0]  ExtMaxBytes = 3'd4;

  typedef struct packed {
    logic [7:0] path_byte;
    logic       end_of_path;
  } beat_t;

  typedef struct packed {
    logic [31:0] dir_hash;
    logic [31:0] name_hash;
    logic [31:0] ext_code;
  } result_t;

  function automatic logic [7:0] norm_byte(input logic [7:0] b);
    logic [7:0] r;
    r = b;
    if (b >= UpperFirst && b <= UpperLast) begin
      r = b + CaseOffset;
    end else if (b == AltSepChar) begin
      r = SepChar;
    end
    return r;
  endfunction

  // One byte through the reflected CRC: eight shift-and-xor steps on the
  // low byte, then combine with the upper bits of the old value.
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] v;
    v = {24'd0, crc[7:0] ^ b};
    for (int k = 0; k < 8; k++) begin
      v = v[0] ? (CrcPoly ^ (v >> 1)) : (v >> 1);
    end
    return v ^ (crc >> 8);
  endfunction

endpackage

@@ hw/rtl/prid_in_if.sv @@
// Input channel of the path resource-ID block: one path byte per beat.
// Standalone; no package dependency.
`timescale 1ns / 1ps

interface prid_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] path_byte;
  logic       end_of_path;

  modport source (output valid, output path_byte, output end_of_path, input ready);
  modport sink   (input valid, input path_byte, input end_of_path, output ready);
endinterface

@@ hw/rtl/prid_out_if.sv @@
// Output channel of the path resource-ID block: one result beat per path.
// Standalone; no package dependency.
`timescale 1ns / 1ps

interface prid_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] dir_hash;
  logic [31:0] name_hash;
  logic [31:0] ext_code;

  modport source (output valid, output dir_hash, output name_hash, output ext_code,
                  input ready);
  modport sink   (input valid, input dir_hash, input name_hash, input ext_code,
                  output ready);
endinterface

@@ hw/rtl/prid_tracker.sv @@
// Per-path state of the resource-ID block: running CRCs, separator and dot
// snapshots, and extension packing. Depends on prid_pkg.
`timescale 1ns / 1ps

module prid_tracker (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  prid_pkg::beat_t  beat_i,
  output prid_pkg::result_t result_o
);

  logic [31:0] whole_q, whole_d;
  logic [31:0] dir_q, dir_d;
  logic [31:0] seg_q, seg_d;
  logic [31:0] stem_q, stem_d;
  logic [31:0] ext_q, ext_d;
  logic [2:0]  cnt_q, cnt_d;
  logic        dot_q, dot_d;
  logic [7:0]  nb;

  always_comb begin
    nb      = prid_pkg::norm_byte(beat_i.path_byte);
    whole_d = prid_pkg::crc_byte(whole_q, nb);
    dir_d   = dir_q;
    seg_d   = seg_q;
    stem_d  = stem_q;
    ext_d   = ext_q;
    cnt_d   = cnt_q;
    dot_d   = dot_q;
    if (nb == prid_pkg::SepChar) begin
      dir_d = whole_q;
      seg_d = '0;
      dot_d = 1'b0;
      ext_d = '0;
      cnt_d = '0;
    end else begin
      if (nb == prid_pkg::DotChar) begin
        stem_d = seg_q;
        dot_d  = 1'b1;
        ext_d  = '0;
        cnt_d  = '0;
      end else if (dot_q && cnt_q < prid_pkg::ExtMaxBytes) begin
        ext_d = ext_q | ({24'd0, nb} << {cnt_q[1:0], 3'b000});
        cnt_d = cnt_q + 3'd1;
      end
      seg_d = prid_pkg::crc_byte(seg_q, nb);
    end
    result_o.dir_hash  = dir_d;
    result_o.name_hash = dot_d ? stem_d : seg_d;
    result_o.ext_code  = dot_d ? ext_d : 32'd0;
  end

  // The final byte of a path leaves every register cleared for the next one.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      whole_q <= '0;
      dir_q   <= '0;
      seg_q   <= '0;
      stem_q  <= '0;
      ext_q   <= '0;
      cnt_q   <= '0;
      dot_q   <= 1'b0;
    end else if (step_i && beat_i.end_of_path) begin
      whole_q <= '0;
      dir_q   <= '0;
      seg_q   <= '0;
      stem_q  <= '0;
      ext_q   <= '0;
      cnt_q   <= '0;
      dot_q   <= 1'b0;
    end else if (step_i) begin
      whole_q <= whole_d;
      dir_q   <= dir_d;
      seg_q   <= seg_d;
      stem_q  <= stem_d;
      ext_q   <= ext_d;
      cnt_q   <= cnt_d;
      dot_q   <= dot_d;
    end
  end

endmodule

@@ hw/rtl/path_resource_id_crc32.sv @@
// Top level of the path resource-ID block: input register, tracker and
// result register. Depends on prid_pkg, prid_in_if, prid_out_if, prid_tracker.
`timescale 1ns / 1ps

//  channel | dir | beat contents                       | when
//  in_i    | in  | path_byte, end_of_path              | one beat per path byte
//  out_o   | out | dir_hash, name_hash, ext_code       | one beat per path
//
// One byte per cycle while the input is not stalled; a result is offered after the final byte
// passes through the input register into the result register, unless an earlier result still waits there.
// The byte CRC update between the input register and the state sets the cycle.
// rst_ni clears all path state and both valid flags at once.
// Non-final bytes never wait on the output; a final byte waits in the input
// register only while an earlier result is still held and not taken.

module path_resource_id_crc32 (
  input  logic       clk_i,
  input  logic       rst_ni,
  prid_in_if.sink    in_i,
  prid_out_if.source out_o
);

  prid_pkg::beat_t   s1_q;
  logic              s1_valid_q;
  prid_pkg::result_t res_q;
  prid_pkg::result_t res_d;
  logic              res_valid_q;
  logic              res_free;
  logic              s1_adv;
  logic              in_acc;

  assign res_free    = !res_valid_q || out_o.ready;
  assign s1_adv      = s1_valid_q && (!s1_q.end_of_path || res_free);
  assign in_i.ready  = !s1_valid_q || s1_adv;
  assign in_acc      = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= in_acc || (s1_valid_q && !s1_adv);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_q.path_byte   <= in_i.path_byte;
      s1_q.end_of_path <= in_i.end_of_path;
    end
  end

  prid_tracker u_tracker (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (s1_adv),
    .beat_i   (s1_q),
    .result_o (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (s1_adv && s1_q.end_of_path) begin
      res_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_q.end_of_path) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid     = res_valid_q;
  assign out_o.dir_hash  = res_q.dir_hash;
  assign out_o.name_hash = res_q.name_hash;
  assign out_o.ext_code  = res_q.ext_code;

`ifndef ASSERT_OFF
  // An empty result register never holds off the input.
  a_ready_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !res_valid_q |-> in_i.ready)
    else $error("input stalled while result register empty");

  // A held byte stalls only behind a waiting result.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s1_adv) |-> (res_valid_q && !out_o.ready && s1_q.end_of_path))
    else $error("input register stalled without a blocked result");

  // A new result is loaded only from a final byte.
  a_result_from_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_adv && !s1_q.end_of_path) |=> (res_valid_q == ($past(res_valid_q) &&
                                                     !$past(out_o.ready))))
    else $error("result changed on a non-final byte");
`endif

endmodule
